### rtl/tcd_pkg.sv
`default_nettype none

package tcd_pkg;

    // Result actions.
    localparam logic [1:0] ACT_DROP  = 2'd0;
    localparam logic [1:0] ACT_PROG  = 2'd1;
    localparam logic [1:0] ACT_HOLD  = 2'd2;
    localparam logic [1:0] ACT_MERGE = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_LOW_MOTION     = 3'd0;
    localparam logic [2:0] REG_LOST_TRACK     = 3'd1;
    localparam logic [2:0] REG_SCENE_FIELD    = 3'd2;
    localparam logic [2:0] REG_SCENE_TEMPORAL = 3'd3;
    localparam logic [2:0] REG_QUANT_SLACK    = 3'd4;
    localparam logic [2:0] REG_DROP_MODE      = 3'd5;
    localparam logic [2:0] REG_ANALYSIS_MODE  = 3'd6;
    localparam logic [2:0] REG_START_PHASE    = 3'd7;

    // Drop rule modes.
    localparam logic [1:0] DROP_NONE  = 2'd0;
    localparam logic [1:0] DROP_FIFTH = 2'd1;
    localparam logic [1:0] DROP_RATIO = 2'd2;

    // Phase code for an untracked cadence.
    localparam logic [3:0] PHASE_UNTRACKED = 4'hF;

    // Field widths.
    localparam int unsigned DIFF_W = 16;
    localparam int unsigned PEAK_W = 13;
    localparam int unsigned PROD_W = DIFF_W + PEAK_W;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;        // capture the input item
        logic mul_first;   // even_diff * temporal_diff
        logic mul_second;  // odd_diff * noise_diff
        logic commit;      // decide, update state, load the result register
    } tcd_cmd_t;

endpackage

`default_nettype wire

### rtl/tcd_ctrl.sv
`default_nettype none

module tcd_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tcd_pkg::tcd_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL_A  = 2'd1;
    localparam logic [1:0] ST_MUL_B  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // The result slot can take a new item when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_first = 1'b1;
                state_next    = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_second = 1'b1;
                state_next     = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tcd_datapath.sv
`default_nettype none

module tcd_datapath
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tcd_pkg::tcd_cmd_t            cmd,
    input  wire logic [tcd_pkg::DIFF_W-1:0]   even_diff,
    input  wire logic [tcd_pkg::DIFF_W-1:0]   odd_diff,
    input  wire logic [tcd_pkg::PEAK_W-1:0]   noise_diff,
    input  wire logic [tcd_pkg::PEAK_W-1:0]   temporal_diff,
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [15:0]                  cfg_data,
    output logic [1:0]                        action,
    output logic                              emit,
    output logic                              rate_dropped
);

    // Checks whether two values are within a fraction of their sum.
    function automatic logic near_by(input logic [15:0] a, input logic [15:0] b,
                                     input logic [1:0] sh);
        logic [15:0] d;
        logic [16:0] s;
        d = (a > b) ? (a - b) : (b - a);
        s = {1'b0, a} + {1'b0, b};
        near_by = ({1'b0, d} < (s >> sh));
    endfunction

    // Configuration registers.
    logic [15:0] low_motion_reg;
    logic [15:0] lost_track_reg;
    logic [15:0] scene_field_reg;
    logic [15:0] scene_temporal_reg;
    logic [15:0] quant_slack_reg;
    logic [1:0]  drop_mode_reg;
    logic        analysis_mode_reg;

    // Cadence state.
    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [15:0] prev_odd_reg;
    logic [15:0] prev_odd_next;
    logic [12:0] prev_noise_reg;
    logic [12:0] prev_noise_next;
    logic [12:0] prev_temporal_reg;
    logic [12:0] prev_temporal_next;
    logic [2:0]  since_drop_reg;
    logic [2:0]  since_drop_next;
    logic [31:0] frames_in_reg;
    logic [31:0] frames_in_next;
    logic [31:0] frames_out_reg;
    logic [31:0] frames_out_next;

    // Captured item and products.
    logic [15:0] e_reg;
    logic [15:0] o_reg;
    logic [12:0] n_reg;
    logic [12:0] t_reg;
    logic [tcd_pkg::PROD_W-1:0] prod_et_reg;
    logic [tcd_pkg::PROD_W-1:0] prod_on_reg;
    logic [tcd_pkg::PROD_W-1:0] product;

    // Result register.
    logic [1:0]  action_reg;
    logic [1:0]  action_next;
    logic        emit_reg;
    logic        emit_next;
    logic        rdrop_reg;
    logic        rdrop_next;

    // Decision terms.
    logic [3:0]  phase_adv;
    logic [15:0] e16;
    logic [15:0] o16;
    logic [15:0] n16;
    logic [15:0] t16;
    logic [15:0] pn16;
    logic        scene_cut;
    logic        noise_ok;
    logic        low_motion;
    logic        field_hold;
    logic        ph_low;
    logic [1:0]  act_aggr;
    logic [3:0]  phase_aggr;
    logic        restore_prev;
    logic [2:0]  since_inc;
    logic        drop_flag;
    logic        ratio_ok;
    logic [31:0] frames_in_inc;
    logic [34:0] in_scaled;
    logic [34:0] out_scaled;

    assign action       = action_reg;
    assign emit         = emit_reg;
    assign rate_dropped = rdrop_reg;

    // One shared multiplier, used for both products of each item.
    assign product = {13'd0, (cmd.mul_first ? e_reg : o_reg)}
                   * {16'd0, (cmd.mul_first ? t_reg : n_reg)};

    assign e16  = e_reg;
    assign o16  = o_reg;
    assign n16  = {3'd0, n_reg};
    assign t16  = {3'd0, t_reg};
    assign pn16 = {3'd0, prev_noise_reg};

    // Phase step: tracked phases count modulo five.
    always_comb
    begin
        case (phase_reg)
            4'd0:    phase_adv = 4'd1;
            4'd1:    phase_adv = 4'd2;
            4'd2:    phase_adv = 4'd3;
            4'd3:    phase_adv = 4'd4;
            4'd4:    phase_adv = 4'd0;
            4'd5:    phase_adv = 4'd1;
            4'd6:    phase_adv = 4'd2;
            4'd7:    phase_adv = 4'd3;
            default: phase_adv = tcd_pkg::PHASE_UNTRACKED;
        endcase
    end

    // Metric tests used by aggressive mode.
    assign scene_cut = (e_reg > scene_field_reg) && (o_reg > scene_field_reg)
                    && (t16 > scene_temporal_reg)
                    && (t16 > ({3'd0, prev_temporal_reg} + {1'b0, prev_temporal_reg, 2'b00}))
                    && ({t_reg, 1'b0} > {1'b0, n_reg});
    assign noise_ok  = ({4'd0, n_reg} + {1'b0, quant_slack_reg}) > {4'd0, t_reg};
    assign low_motion = (e_reg < low_motion_reg) && (o_reg < low_motion_reg)
                     && near_by(e16, o16, 2'd3) && near_by(n16, t16, 2'd3)
                     && near_by(n16, pn16, 2'd3);
    assign field_hold = ({prod_et_reg, 1'b0} < {1'b0, prod_on_reg});

    // Aggressive cadence analysis.
    always_comb
    begin
        act_aggr     = tcd_pkg::ACT_PROG;
        phase_aggr   = phase_adv;
        restore_prev = 1'b0;
        ph_low       = 1'b0;
        if ((phase_adv == 4'd4) && scene_cut)
        begin
            act_aggr   = tcd_pkg::ACT_DROP;
            phase_aggr = tcd_pkg::PHASE_UNTRACKED;
        end
        else if ((phase_adv == 4'd4) && noise_ok && near_by(e16, prev_odd_reg, 2'd2))
        begin
            act_aggr = tcd_pkg::ACT_MERGE;
        end
        else if ((phase_adv == 4'd4) && noise_ok && low_motion)
        begin
            act_aggr     = tcd_pkg::ACT_HOLD;
            phase_aggr   = 4'd3;
            restore_prev = 1'b1;
        end
        else
        begin
            // Phase four with too much noise loses track.
            if ((phase_adv == 4'd4) && !noise_ok)
            begin
                phase_aggr = tcd_pkg::PHASE_UNTRACKED;
            end
            ph_low = phase_aggr[3] || (phase_aggr < 4'd3);
            if (field_hold)
            begin
                act_aggr   = tcd_pkg::ACT_HOLD;
                phase_aggr = 4'd3;
            end
            else if (ph_low && (n16 > scene_temporal_reg) && ({1'b0, n_reg} > {t_reg, 1'b0}))
            begin
                act_aggr = tcd_pkg::ACT_MERGE;
            end
            else if (ph_low && (n16 > scene_temporal_reg) && ({1'b0, n_reg} > {pn16[12:0], 1'b0})
                     && (e_reg > scene_field_reg) && (o_reg > scene_field_reg))
            begin
                act_aggr = tcd_pkg::ACT_DROP;
            end
            else if (phase_aggr[3])
            begin
                act_aggr = ({1'b0, n_reg, 2'b00} > ({3'd0, t_reg} + {1'b0, t_reg, 2'b00}))
                         ? tcd_pkg::ACT_MERGE : tcd_pkg::ACT_PROG;
            end
            else if (phase_aggr < 4'd3)
            begin
                act_aggr = tcd_pkg::ACT_PROG;
            end
            else if (phase_aggr == 4'd3)
            begin
                if ((e_reg > lost_track_reg) && (e_reg > o_reg) && (t_reg > n_reg))
                begin
                    act_aggr   = tcd_pkg::ACT_PROG;
                    phase_aggr = tcd_pkg::PHASE_UNTRACKED;
                end
                else
                begin
                    act_aggr = tcd_pkg::ACT_HOLD;
                end
            end
            else
            begin
                act_aggr = tcd_pkg::ACT_MERGE;
            end
        end
    end

    // Rate-drop rule and counters.
    assign frames_in_inc = (frames_in_reg == 32'hFFFF_FFFF) ? frames_in_reg
                                                            : frames_in_reg + 32'd1;
    assign since_inc     = (since_drop_reg == 3'd7) ? since_drop_reg : since_drop_reg + 3'd1;
    assign in_scaled     = {1'b0, frames_in_inc, 2'b00};
    assign out_scaled    = {3'd0, frames_out_reg} + {1'b0, frames_out_reg, 2'b00};
    assign ratio_ok      = (in_scaled <= out_scaled);

    always_comb
    begin
        frames_in_next     = frames_in_inc;
        frames_out_next    = frames_out_reg;
        since_drop_next    = since_drop_reg;
        emit_next          = 1'b0;
        rdrop_next         = 1'b0;
        drop_flag          = 1'b0;
        prev_odd_next      = prev_odd_reg;
        prev_noise_next    = prev_noise_reg;
        prev_temporal_next = prev_temporal_reg;

        if (analysis_mode_reg)
        begin
            action_next = act_aggr;
            phase_next  = phase_aggr;
            if (!restore_prev)
            begin
                prev_odd_next      = o_reg;
                prev_noise_next    = n_reg;
                prev_temporal_next = t_reg;
            end
        end
        else
        begin
            phase_next = phase_adv;
            case (phase_adv)
                4'd3:    action_next = tcd_pkg::ACT_HOLD;
                4'd4:    action_next = tcd_pkg::ACT_MERGE;
                default: action_next = tcd_pkg::ACT_PROG;
            endcase
        end

        if ((action_next == tcd_pkg::ACT_PROG) || (action_next == tcd_pkg::ACT_MERGE))
        begin
            if ((drop_mode_reg == tcd_pkg::DROP_FIFTH) || (drop_mode_reg == tcd_pkg::DROP_RATIO))
            begin
                since_drop_next = since_inc;
                drop_flag       = (since_inc >= 3'd5)
                               && ((drop_mode_reg != tcd_pkg::DROP_RATIO) || ratio_ok);
            end
            if (drop_flag)
            begin
                since_drop_next = 3'd0;
                rdrop_next      = 1'b1;
            end
            else
            begin
                emit_next = 1'b1;
                if (frames_out_reg != 32'hFFFF_FFFF)
                begin
                    frames_out_next = frames_out_reg + 32'd1;
                end
            end
        end
        else
        begin
            since_drop_next = 3'd0;
        end
    end

    // Item capture, products and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg <= even_diff;
            o_reg <= odd_diff;
            n_reg <= noise_diff;
            t_reg <= temporal_diff;
        end
        if (cmd.mul_first)
        begin
            prod_et_reg <= product;
        end
        if (cmd.mul_second)
        begin
            prod_on_reg <= product;
        end
        if (cmd.commit)
        begin
            action_reg <= action_next;
            emit_reg   <= emit_next;
            rdrop_reg  <= rdrop_next;
        end
    end

    // Configuration and cadence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_motion_reg     <= 16'd440;
            lost_track_reg     <= 16'd720;
            scene_field_reg    <= 16'd2500;
            scene_temporal_reg <= 16'd2500;
            quant_slack_reg    <= 16'd800;
            drop_mode_reg      <= tcd_pkg::DROP_NONE;
            analysis_mode_reg  <= 1'b1;
            phase_reg          <= tcd_pkg::PHASE_UNTRACKED;
            prev_odd_reg       <= '0;
            prev_noise_reg     <= '0;
            prev_temporal_reg  <= '0;
            since_drop_reg     <= '0;
            frames_in_reg      <= '0;
            frames_out_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            phase_reg         <= phase_next;
            prev_odd_reg      <= prev_odd_next;
            prev_noise_reg    <= prev_noise_next;
            prev_temporal_reg <= prev_temporal_next;
            since_drop_reg    <= since_drop_next;
            frames_in_reg     <= frames_in_next;
            frames_out_reg    <= frames_out_next;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcd_pkg::REG_LOW_MOTION:     low_motion_reg     <= cfg_data;
                tcd_pkg::REG_LOST_TRACK:     lost_track_reg     <= cfg_data;
                tcd_pkg::REG_SCENE_FIELD:    scene_field_reg    <= cfg_data;
                tcd_pkg::REG_SCENE_TEMPORAL: scene_temporal_reg <= cfg_data;
                tcd_pkg::REG_QUANT_SLACK:    quant_slack_reg    <= cfg_data;
                tcd_pkg::REG_DROP_MODE:      drop_mode_reg      <= cfg_data[1:0];
                tcd_pkg::REG_ANALYSIS_MODE:  analysis_mode_reg  <= cfg_data[0];
                tcd_pkg::REG_START_PHASE:
                begin
                    // Any negative start phase means untracked.
                    phase_reg <= cfg_data[3] ? tcd_pkg::PHASE_UNTRACKED : cfg_data[3:0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/telecine_cadence_decision.sv
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: even, odd, noise, temporal diff
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: action, emit, rate_dropped
// cfg       in         cfg_we                        cfg_index, cfg_data
//
// Each item is handled in order: capture, two passes through one shared 16x13
// multiplier, and a decision cycle that updates the cadence state.
// The next item is accepted while a finished result still waits in the output register.
// If the output register is still full at the decision cycle, the block waits there.
// Reset puts all limits at their defaults, the cadence untracked, and clears counters.

module telecine_cadence_decision
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] even_diff, [31:16] odd_diff, [44:32] noise_diff, [57:45] temporal_diff
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] action, [2] emit, [3] rate_dropped
    output logic [7:0]       m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tcd_pkg::tcd_cmd_t cmd;
    logic [1:0]        action;
    logic              emit;
    logic              rate_dropped;

    tcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    tcd_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .even_diff     (s_axis_tdata[15:0]),
        .odd_diff      (s_axis_tdata[31:16]),
        .noise_diff    (s_axis_tdata[44:32]),
        .temporal_diff (s_axis_tdata[57:45]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .emit          (emit),
        .rate_dropped  (rate_dropped)
    );

    assign m_axis_tdata = {4'd0, rate_dropped, emit, action};

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic ANALYSIS_FIXED      = 1'b0;
    localparam logic ANALYSIS_AGGRESSIVE = 1'b1;
    localparam int unsigned COUNT_LIMIT  = 32'hFFFF_FFFF;
    localparam int unsigned SINCE_LIMIT  = 7;
    localparam int unsigned REPORT_LIMIT = 50;

    // One decision as it leaves the block.
    typedef struct packed {
        logic [1:0] action;
        logic       emit;
        logic       rate_dropped;
    } cadence_result_t;

    // Tracks the cadence state alongside the block and checks each decision in order.
    class cadence_scoreboard;
        int unsigned low_motion_limit, lost_track_limit, scene_field_limit;
        int unsigned scene_temporal_limit, quantization_slack;
        logic [1:0]  drop_mode;
        logic        analysis_mode;
        int          phase;
        int unsigned prev_odd, prev_noise, prev_temporal;
        int unsigned since_drop, frames_in, frames_out;
        cadence_result_t expected_decisions[$];
        int unsigned failures;

        function new();
            low_motion_limit     = 440;
            lost_track_limit     = 720;
            scene_field_limit    = 2500;
            scene_temporal_limit = 2500;
            quantization_slack   = 800;
            drop_mode            = tcd_pkg::DROP_NONE;
            analysis_mode        = ANALYSIS_AGGRESSIVE;
            load_phase(tcd_pkg::PHASE_UNTRACKED);
            prev_odd             = 0;
            prev_noise           = 0;
            prev_temporal        = 0;
            since_drop           = 0;
            frames_in            = 0;
            frames_out           = 0;
            failures             = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $error("%s", msg);
        endfunction

        function int pending();
            return expected_decisions.size();
        endfunction

        // Any negative code means untracked; codes five to seven are kept as they are.
        function void load_phase(logic [3:0] code);
            phase = code[3] ? -1 : int'(code[2:0]);
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] value);
            case (idx)
                tcd_pkg::REG_LOW_MOTION:     low_motion_limit = 32'(value);
                tcd_pkg::REG_LOST_TRACK:     lost_track_limit = 32'(value);
                tcd_pkg::REG_SCENE_FIELD:    scene_field_limit = 32'(value);
                tcd_pkg::REG_SCENE_TEMPORAL: scene_temporal_limit = 32'(value);
                tcd_pkg::REG_QUANT_SLACK:    quantization_slack = 32'(value);
                tcd_pkg::REG_DROP_MODE:      drop_mode = value[1:0];
                tcd_pkg::REG_ANALYSIS_MODE:  analysis_mode = value[0];
                tcd_pkg::REG_START_PHASE:    load_phase(value[3:0]);
                default: ;
            endcase
        endfunction

        function void step_phase();
            if (phase >= 0)
                phase = (phase + 1) % 5;
        endfunction

        // True when the two values differ by less than their sum scaled down.
        function bit close_by(int unsigned a, int unsigned b, int unsigned sh);
            int unsigned gap;
            gap = (a > b) ? a - b : b - a;
            return gap < ((a + b) >> sh);
        endfunction

        function logic [1:0] fixed_action();
            step_phase();
            if (phase == 3)
                return tcd_pkg::ACT_HOLD;
            if (phase == 4)
                return tcd_pkg::ACT_MERGE;
            return tcd_pkg::ACT_PROG;
        endfunction

        function logic [1:0] aggressive_action(int unsigned e, int unsigned o,
                                               int unsigned n, int unsigned t);
            int unsigned po, pn, pt;
            longint unsigned cross_even, cross_odd;
            po = prev_odd;
            pn = prev_noise;
            pt = prev_temporal;
            step_phase();
            prev_odd      = o;
            prev_noise    = n;
            prev_temporal = t;

            // Second-field position: scene cut, confirmed field match or duplicate.
            if (phase == 4)
            begin
                if (e > scene_field_limit && o > scene_field_limit
                    && t > scene_temporal_limit && t > 5 * pt && 2 * t > n)
                begin
                    phase = -1;
                    return tcd_pkg::ACT_DROP;
                end
                if (n + quantization_slack > t)
                begin
                    if (close_by(e, po, 2))
                        return tcd_pkg::ACT_MERGE;
                    if (e < low_motion_limit && o < low_motion_limit && close_by(e, o, 3)
                        && close_by(n, t, 3) && close_by(n, pn, 3))
                    begin
                        prev_odd      = po;
                        prev_noise    = pn;
                        prev_temporal = pt;
                        phase         = 3;
                        return tcd_pkg::ACT_HOLD;
                    end
                end
                else
                begin
                    phase = -1;
                end
            end

            // A combed frame catches sync at the first-field position.
            cross_even = 64'(e) * 64'd2;
            cross_even = cross_even * 64'(t);
            cross_odd  = 64'(o);
            cross_odd  = cross_odd * 64'(n);
            if (cross_even < cross_odd)
            begin
                phase = 3;
                return tcd_pkg::ACT_HOLD;
            end

            if (phase < 3 && n > scene_temporal_limit)
            begin
                if (n > 2 * t)
                    return tcd_pkg::ACT_MERGE;
                if (n > 2 * pn && e > scene_field_limit && o > scene_field_limit)
                    return tcd_pkg::ACT_DROP;
            end

            if (phase < 0)
                return (4 * n > 5 * t) ? tcd_pkg::ACT_MERGE : tcd_pkg::ACT_PROG;
            if (phase < 3)
                return tcd_pkg::ACT_PROG;
            if (phase == 3)
            begin
                if (e > lost_track_limit && e > o && t > n)
                begin
                    phase = -1;
                    return tcd_pkg::ACT_PROG;
                end
                return tcd_pkg::ACT_HOLD;
            end
            return tcd_pkg::ACT_MERGE;
        endfunction

        // Works out the decision for an accepted frame and queues it.
        function void note_frame(logic [63:0] item);
            int unsigned e, o, n, t;
            longint unsigned in_scaled, out_scaled;
            bit withheld;
            cadence_result_t r;
            e = 32'(item[15:0]);
            o = 32'(item[31:16]);
            n = 32'(item[44:32]);
            t = 32'(item[57:45]);
            if (frames_in != COUNT_LIMIT)
                frames_in++;
            r.action = (analysis_mode == ANALYSIS_AGGRESSIVE) ?
                       aggressive_action(e, o, n, t) : fixed_action();
            r.emit         = 1'b0;
            r.rate_dropped = 1'b0;
            if (r.action == tcd_pkg::ACT_PROG || r.action == tcd_pkg::ACT_MERGE)
            begin
                withheld = 1'b0;
                if (drop_mode == tcd_pkg::DROP_FIFTH || drop_mode == tcd_pkg::DROP_RATIO)
                begin
                    if (since_drop < SINCE_LIMIT)
                        since_drop++;
                    withheld = (since_drop >= 5);
                    if (drop_mode == tcd_pkg::DROP_RATIO)
                    begin
                        in_scaled  = 64'(frames_in);
                        out_scaled = 64'(frames_out);
                        withheld   = withheld && (in_scaled * 4 <= out_scaled * 5);
                    end
                end
                if (withheld)
                begin
                    since_drop     = 0;
                    r.rate_dropped = 1'b1;
                end
                else
                begin
                    if (frames_out != COUNT_LIMIT)
                        frames_out++;
                    r.emit = 1'b1;
                end
            end
            else
            begin
                since_drop = 0;
            end
            expected_decisions.push_back(r);
        endfunction

        function void check_decision(logic [7:0] data);
            cadence_result_t want;
            if (expected_decisions.size() == 0)
            begin
                flag($sformatf("decision with none outstanding: tdata %02h", data));
                return;
            end
            want = expected_decisions.pop_front();
            if (data[1:0] !== want.action)
                flag($sformatf("action: expected %0d, actual %0d", want.action, data[1:0]));
            if (data[2] !== want.emit)
                flag($sformatf("emit: expected %0d, actual %0d", want.emit, data[2]));
            if (data[3] !== want.rate_dropped)
                flag($sformatf("rate_dropped: expected %0d, actual %0d",
                               want.rate_dropped, data[3]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] even_diff, [31:16] odd_diff, [44:32] noise_diff, [57:45] temporal_diff
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] action, [2] emit, [3] rate_dropped
    logic [7:0]  m_axis_tdata;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = tcd_pkg::REG_LOW_MOTION;
    logic [15:0] cfg_data      = '0;

    cadence_scoreboard sb;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int unsigned hold_left      = 0;
    int          pattern_pos    = 0;
    int          last_odd       = 0;
    int          last_noise     = 0;

    telecine_cadence_decision dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watch both handshakes; the result is checked before the new item is noted.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_decision(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready === 1'b1)
                sb.note_frame(s_axis_tdata);
        end
    end

    initial
    begin
        #5_000_000;
        $display("telecine_cadence_decision: mismatch");
        $finish;
    end

    function automatic logic [63:0] pack_frame(int e, int o, int n, int t);
        logic [15:0] even_v, odd_v;
        logic [12:0] noise_v, temporal_v;
        even_v     = (e < 0) ? 16'd0 : (e > 65535) ? 16'hFFFF : 16'(e);
        odd_v      = (o < 0) ? 16'd0 : (o > 65535) ? 16'hFFFF : 16'(o);
        noise_v    = (n < 0) ? 13'd0 : (n > 8191) ? 13'h1FFF : 13'(n);
        temporal_v = (t < 0) ? 13'd0 : (t > 8191) ? 13'h1FFF : 13'(t);
        return {6'b0, temporal_v, noise_v, odd_v, even_v};
    endfunction

    // Mostly a 3:2 run with random content; the rest are scene cuts, duplicates,
    // values around the current limits and plain noise.
    function automatic logic [63:0] random_frame();
        int e, o, n, t, pick, lim;
        logic [63:0] item;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            case (pattern_pos)
                3:
                begin
                    e = $urandom_range(300);
                    o = $urandom_range(65535, 2000);
                    n = $urandom_range(8191, 1500);
                    t = $urandom_range(400);
                end
                4:
                begin
                    e = last_odd + $urandom_range(last_odd / 4 + 8) - (last_odd / 8 + 4);
                    o = $urandom_range(3000);
                    n = $urandom_range(3000);
                    t = $urandom_range(n + 1200);
                end
                default:
                begin
                    e = $urandom_range(3000);
                    o = $urandom_range(3000);
                    n = $urandom_range(2000);
                    t = $urandom_range(3000);
                end
            endcase
            pattern_pos = (pattern_pos + 1) % 5;
        end
        else if (pick < 75)
        begin
            e = $urandom_range(65535);
            o = $urandom_range(65535);
            n = $urandom_range(8191);
            t = $urandom_range(8191);
        end
        else if (pick < 83)
        begin
            e = $urandom_range(65535, 2000);
            o = $urandom_range(65535, 2000);
            t = $urandom_range(8191, 2000);
            n = $urandom_range(t);
        end
        else if (pick < 91)
        begin
            e = $urandom_range(500);
            o = e + $urandom_range(40) - 20;
            n = last_noise + $urandom_range(30) - 15;
            t = n + $urandom_range(30) - 15;
        end
        else
        begin
            case ($urandom_range(4))
                0: lim = sb.low_motion_limit;
                1: lim = sb.lost_track_limit;
                2: lim = sb.scene_field_limit;
                3: lim = sb.scene_temporal_limit;
                default: lim = sb.quantization_slack;
            endcase
            e = lim + $urandom_range(2) - 1;
            o = lim + $urandom_range(2) - 1;
            n = (lim > 8191) ? $urandom_range(8191) : lim + $urandom_range(2) - 1;
            t = (lim > 8191) ? $urandom_range(8191) : lim + $urandom_range(2) - 1;
        end
        item       = pack_frame(e, o, n, t);
        last_odd   = int'(item[31:16]);
        last_noise = int'(item[44:32]);
        return item;
    endfunction

    // Offer one frame, with random idle cycles first, and wait for it to be taken.
    task automatic send_frame(input logic [63:0] item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
    endtask

    // Stop offering frames until every queued decision has come back.
    task automatic drain_results(input bit settle);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        if (settle)
            repeat (8) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // Limits are all zero or all ones in two runs and random otherwise; the start
    // phase walks through every code, and the drop mode through all four values.
    task automatic configure(input int run);
        logic [15:0] lim [5];
        logic [3:0]  start_code;
        for (int k = 0; k < 5; k++)
        begin
            if (run == 1)
                lim[k] = 16'h0000;
            else if (run == 2)
                lim[k] = 16'hFFFF;
            else
            begin
                case ($urandom_range(3))
                    0: lim[k] = 16'($urandom_range(2600, 400));
                    1: lim[k] = 16'($urandom_range(4000));
                    2: lim[k] = 16'($urandom_range(65535));
                    default: lim[k] = 16'($urandom_range(1500, 200));
                endcase
            end
        end
        start_code = run[3:0];
        put_reg(tcd_pkg::REG_LOW_MOTION, lim[0]);
        put_reg(tcd_pkg::REG_LOST_TRACK, lim[1]);
        put_reg(tcd_pkg::REG_SCENE_FIELD, lim[2]);
        put_reg(tcd_pkg::REG_SCENE_TEMPORAL, lim[3]);
        put_reg(tcd_pkg::REG_QUANT_SLACK, lim[4]);
        put_reg(tcd_pkg::REG_DROP_MODE, 16'(run % 4));
        put_reg(tcd_pkg::REG_ANALYSIS_MODE,
                16'((run % 5 == 0) ? ANALYSIS_FIXED : ANALYSIS_AGGRESSIVE));
        put_reg(tcd_pkg::REG_START_PHASE, {{12{start_code[3]}}, start_code});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames under reset settings: field extremes and each decision path.
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        send_frame(pack_frame(0, 0, 0, 0));
        send_frame(pack_frame(65535, 65535, 8191, 8191));
        send_frame(pack_frame(0, 65535, 8191, 0));
        send_frame(pack_frame(65000, 100, 1000, 500));
        send_frame(pack_frame(100, 100, 10, 10));
        send_frame(pack_frame(100, 100, 10, 10));
        send_frame(pack_frame(100, 100, 10, 10));
        send_frame(pack_frame(5000, 100, 10, 5000));
        send_frame(pack_frame(0, 60000, 4000, 0));
        send_frame(pack_frame(10, 60000, 4000, 0));
        send_frame(pack_frame(30000, 30000, 100, 8000));
        send_frame(pack_frame(0, 50000, 200, 0));
        send_frame(pack_frame(300, 300, 210, 200));
        send_frame(pack_frame(1000, 1000, 100, 5000));
        send_frame(pack_frame(500, 500, 3000, 100));
        send_frame(pack_frame(500, 500, 1000, 700));
        send_frame(pack_frame(65535, 0, 0, 0));
        send_frame(pack_frame(0, 65535, 0, 0));
        send_frame(pack_frame(0, 0, 8191, 0));
        send_frame(pack_frame(0, 0, 0, 8191));
        send_frame(pack_frame(3000, 3000, 8191, 3000));
        send_frame(pack_frame(3000, 3000, 4000, 1000));

        // Random runs, each under fresh settings; the idling pattern changes every four runs.
        for (int run = 0; run < 16; run++)
        begin
            drain_results(1'b1);
            configure(run);
            case (run / 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            for (int i = 0; i < 105; i++)
            begin
                // Long receiver hold-off so that the block backs up onto its input.
                if (run == 6 && i == 30)
                    hold_request = 1'b1;
                // Sender pause until the block has emptied.
                if (run == 11 && i == 50)
                    drain_results(1'b0);
                send_frame(random_frame());
            end
        end

        drain_results(1'b0);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("telecine_cadence_decision: match");
        else
            $display("telecine_cadence_decision: mismatch");
        $finish;
    end

endmodule
